### rtl/mnts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mnts_pkg: shared types, constants and tables of the note tone synth
// Holds the word formats, controller commands and states, the register map,
// and the phase-increment and sine tables built at elaboration.
// ============================================================================
package mnts_pkg;

	localparam int AUDIO_FS         = 48000;
	localparam int PHASE_BITS       = 32;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
	localparam int NOTE_COUNT       = 128;

	localparam int NOTE_LEN_BITS = 20;
	localparam int FADE_LEN_BITS = 16;
	localparam int PEAK_BITS     = 15;
	localparam int CFG_DATA_BITS = 20;
	localparam int CFG_IDX_BITS  = 2;

	localparam logic [NOTE_LEN_BITS-1:0] NOTE_LENGTH_RESET = 20'd960;
	localparam logic [FADE_LEN_BITS-1:0] FADE_LENGTH_RESET = 16'd200;
	localparam logic [PEAK_BITS-1:0]     PEAK_RESET        = 15'd6553;

	localparam logic [CFG_IDX_BITS-1:0] CFG_NOTE_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_LENGTH    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_AMPLITUDE = 2'd2;

	// Fade divider: 16 quotient bits, two per step.
	localparam int DIV_BITS      = 16;
	localparam int DIV_RADIX     = 2;
	localparam int DIV_STEPS     = DIV_BITS / DIV_RADIX;
	localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [6:0] note_number;
		logic       is_rest;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               end_of_note;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic mul1;
		logic mul2;
		logic div_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fade;
	} ctrl_stat_t;

	typedef logic [PHASE_BITS-1:0] inc_rom_t [NOTE_COUNT];
	typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

	localparam longint unsigned SEMITONE_Q24 [12] = '{
		64'd16777216, 64'd17774841, 64'd18831788, 64'd19951584,
		64'd21137968, 64'd22394897, 64'd23726565, 64'd25137421,
		64'd26632170, 64'd28215801, 64'd29893600, 64'd31671167
	};

	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

	// Taylor term divisors (2k+2)(2k+3).
	localparam longint unsigned TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// inc(n) = round(55/8 * 2^((n+3)/12) * 2^PHASE_BITS / AUDIO_FS)
	function automatic inc_rom_t build_inc_rom();
		inc_rom_t rom;
		longint unsigned a;
		longint unsigned d;
		longint unsigned q;
		longint unsigned r;
		int semi;
		int oct;
		semi = 3;
		oct  = 0;
		d    = longint'(AUDIO_FS) << 27;
		for (int n = 0; n < NOTE_COUNT; n++) begin
			a = 64'd55 * SEMITONE_Q24[semi];
			q = 0;
			r = a;
			for (int i = 0; i < oct + PHASE_BITS; i++) begin
				q = q << 1;
				r = r << 1;
				if (r >= d) begin
					r = r - d;
					q = q + 1;
				end
			end
			if ((r << 1) >= d) begin
				q = q + 1;
			end
			rom[n] = q[PHASE_BITS-1:0];
			semi = semi + 1;
			if (semi == 12) begin
				semi = 0;
				oct  = oct + 1;
			end
		end
		return rom;
	endfunction

	// sin(x) for x in [0, pi/2], Q30 in and out
	function automatic longint unsigned sin_q30(longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = 0;
		for (int k = 0; k < 8; k++) begin
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
		end
		return (sum < 0) ? 64'd0 : longint'(sum);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t       rom;
		longint unsigned x;
		longint unsigned v;
		logic            neg;
		for (int j = 0; j < SINE_TABLE_DEPTH; j++) begin
			x   = (TWO_PI_Q30 * longint'(j)) / SINE_TABLE_DEPTH;
			neg = 1'b0;
			if (x >= PI_Q30) begin
				x   = x - PI_Q30;
				neg = 1'b1;
			end
			if (x > HALF_PI_Q30) begin
				x = PI_Q30 - x;
			end
			v = (sin_q30(x) + 64'd16384) >> 15;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			rom[j] = neg ? -$signed(v[15:0]) : $signed(v[15:0]);
		end
		return rom;
	endfunction

	localparam inc_rom_t INC_ROM = build_inc_rom();

endpackage

### rtl/mnts_div.sv
`timescale 1ns / 1ps
// ============================================================================
// mnts_div: iterative restoring divider for the fade scale
// Two quotient bits per step; the quotient must fit in DIV_BITS bits, so the
// upper half of the dividend starts out below the divisor.
// ============================================================================
module mnts_div (
	input  logic                                clk,
	input  logic                                load,
	input  logic                                step,
	input  logic [2*mnts_pkg::DIV_BITS-1:0]     dividend,
	input  logic [mnts_pkg::FADE_LEN_BITS-1:0]  divisor,
	output logic [mnts_pkg::DIV_BITS-1:0]       quotient
);
	import mnts_pkg::*;

	logic [FADE_LEN_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0]      shift_q;
	logic [FADE_LEN_BITS-1:0] rem_d;
	logic [DIV_BITS-1:0]      shift_d;
	logic [FADE_LEN_BITS:0]   trial;

	always_comb begin
		rem_d   = rem_q;
		shift_d = shift_q;
		trial   = '0;
		for (int i = 0; i < DIV_RADIX; i++) begin
			trial   = {rem_d, shift_d[DIV_BITS-1]};
			shift_d = {shift_d[DIV_BITS-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial      = trial - {1'b0, divisor};
				shift_d[0] = 1'b1;
			end
			rem_d = trial[FADE_LEN_BITS-1:0];
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q   <= dividend[2*DIV_BITS-1 -: FADE_LEN_BITS];
			shift_q <= dividend[DIV_BITS-1:0];
		end else if (step) begin
			rem_q   <= rem_d;
			shift_q <= shift_d;
		end
	end

	assign quotient = shift_q;

endmodule

### rtl/mnts_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// mnts_datapath: note state, tables, multipliers and output register
// Keeps the configuration, note position and phase; looks up the sine, scales
// it by peak and fade, and holds the finished word.
// ============================================================================
module mnts_datapath #(
	parameter int POSITION_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mnts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [mnts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  mnts_pkg::in_word_t                  in_data,
	input  mnts_pkg::ctrl_cmd_t                 cmd,
	output mnts_pkg::ctrl_stat_t                stat,
	output mnts_pkg::out_word_t                 out_data
);
	import mnts_pkg::*;

	localparam int NW = ((POSITION_BITS > NOTE_LEN_BITS) ? POSITION_BITS : NOTE_LEN_BITS) + 1;
	localparam int PROD_BITS = 2 * PEAK_BITS;
	localparam int FADE_PROD_BITS = PROD_BITS + FADE_LEN_BITS;
	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic [NOTE_LEN_BITS-1:0] note_length_q;
	logic [FADE_LEN_BITS-1:0] fade_length_q;
	logic [PEAK_BITS-1:0]     peak_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [PHASE_BITS-1:0]    phase_q;

	logic signed [15:0]       sine_q;
	logic                     rest_q;
	logic                     last_q;
	logic                     fade_q;
	logic [FADE_LEN_BITS-1:0] rem_q;
	logic [PROD_BITS-1:0]     prod_q;
	out_word_t                out_q;

	logic [NW-1:0]             pos_ext;
	logic [NW-1:0]             nl_ext;
	logic [NW-1:0]             pos_inc;
	logic [NW-1:0]             rem;
	logic                      last;
	logic                      fade_hit;
	logic [15:0]               sine_mag;
	logic [FADE_PROD_BITS-1:0] fade_prod;
	logic [2*DIV_BITS-1:0]     dividend;
	logic [DIV_BITS-1:0]       quotient;
	logic [PEAK_BITS-1:0]      mag;

	assign pos_ext  = NW'(pos_q);
	assign nl_ext   = NW'(note_length_q);
	assign pos_inc  = pos_ext + NW'(1);
	assign last     = (pos_inc >= nl_ext);
	assign rem      = (nl_ext > pos_ext) ? (nl_ext - pos_ext) : NW'(1);
	assign fade_hit = (fade_length_q != '0) && (rem <= NW'(fade_length_q));

	assign sine_mag  = sine_q[15] ? 16'(-sine_q) : 16'(sine_q);
	assign fade_prod = {{FADE_LEN_BITS{1'b0}}, prod_q} *
	                   {{PROD_BITS{1'b0}}, rem_q};
	assign dividend  = (2*DIV_BITS)'(fade_prod[FADE_PROD_BITS-1:15]);

	mnts_div u_div (
		.clk      (clk),
		.load     (cmd.mul2 && fade_q),
		.step     (cmd.div_step),
		.dividend (dividend),
		.divisor  (fade_length_q),
		.quotient (quotient)
	);

	assign mag = fade_q ? quotient[PEAK_BITS-1:0] : prod_q[PROD_BITS-1:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_length_q <= NOTE_LENGTH_RESET;
			fade_length_q <= FADE_LENGTH_RESET;
			peak_q        <= PEAK_RESET;
			pos_q         <= '0;
			phase_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NOTE_LENGTH:    note_length_q <= cfg_data;
					CFG_FADE_LENGTH:    fade_length_q <= cfg_data[FADE_LEN_BITS-1:0];
					CFG_PEAK_AMPLITUDE: peak_q        <= cfg_data[PEAK_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (last) begin
					pos_q   <= '0;
					phase_q <= '0;
				end else begin
					pos_q <= pos_inc[POSITION_BITS-1:0];
					if (!in_data.is_rest) begin
						phase_q <= phase_q + INC_ROM[in_data.note_number];
					end
				end
			end
		end
	end

	// sine ROM read at the old phase, before the step
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sine_q <= SINE_ROM[phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS]];
			rest_q <= in_data.is_rest;
			last_q <= last;
			fade_q <= fade_hit;
			rem_q  <= rem[FADE_LEN_BITS-1:0];
		end
		if (cmd.mul1) begin
			prod_q <= {{PEAK_BITS{1'b0}}, peak_q} *
			          {{PEAK_BITS{1'b0}}, sine_mag[PEAK_BITS-1:0]};
		end
		if (cmd.load_out) begin
			out_q.end_of_note <= last_q;
			if (rest_q) begin
				out_q.sample <= '0;
			end else if (sine_q[15]) begin
				out_q.sample <= -$signed({1'b0, mag});
			end else begin
				out_q.sample <= $signed({1'b0, mag});
			end
		end
	end

	assign stat.fade = fade_q;
	assign out_data  = out_q;

endmodule

### rtl/mnts_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// mnts_ctrl: sequencer of the note tone synth
// Steps one sample through lookup, multiply and divide, and owns both
// handshakes.
// ============================================================================
module mnts_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  mnts_pkg::ctrl_stat_t  stat,
	output mnts_pkg::ctrl_cmd_t   cmd
);
	import mnts_pkg::*;

	state_t                  state_q;
	state_t                  state_d;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DIV_CNT_BITS-1:0] cnt_d;
	logic                    out_valid_q;
	logic                    out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				cnt_d    = '0;
				state_d  = stat.fade ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register is free or being taken
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		out_valid_d = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/midi_note_tone_synth_with_fade.sv
`timescale 1ns / 1ps
// ============================================================================
// midi_note_tone_synth_with_fade: sine tone per MIDI note with fade-out
// Top level: sequencer plus datapath, one input word per audio sample tick.
// ============================================================================
// Each accepted input word is one sample tick carrying a MIDI note number or
// a rest; each one yields exactly one output word with a signed 16-bit
// sample (same for left and right) and an end-of-note flag on the last
// sample of the note. A sample in the fade window at the end of the note
// passes the sequencer through accept with sine lookup, peak multiply, fade
// multiply, eight radix-4 divider steps and output load; outside it the
// divider steps are skipped. The divider scales by remaining/fade_length.
// The next word is taken the cycle after the result is loaded, even while
// that result still waits in the output register; a further result waits
// only if the previous one has not been taken. Configuration (index 0
// note_length, 1 fade_length, 2 peak_amplitude) is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while idle, as the
// block itself does not enforce it.
// ============================================================================
module midi_note_tone_synth_with_fade #(
	parameter int POSITION_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mnts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [mnts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  mnts_pkg::in_word_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mnts_pkg::out_word_t                 out_data
);
	import mnts_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	// sequencer: walks one word through lookup, scale and divide
	mnts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: note position, phase, tables, multipliers, divider, output
	mnts_datapath #(
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

	// a word is accepted only when the sequencer is free again
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is still in work");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("output word overwritten before it was taken");

	// divider runs only for samples inside the fade window
	a_div_only_in_fade: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> stat.fade)
		else $error("divider stepped outside the fade window");

	// a loaded result is offered in the next cycle
	a_valid_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result not offered");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the MIDI note tone synth with fade-out
// Streams note/rest sample ticks into the block, predicts every output word
// with an independent model of the phase accumulator, sine table, note
// position and fade scaling, and compares each accepted word in order.
// Random stalls on both sides, register changes between phases.
// ============================================================================
module tb_top;
	import mnts_pkg::*;

	localparam int TONE_POS_BITS  = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_PHASES  = 8;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

	// Angles in Q30 radians for building the sine table.
	localparam longint unsigned ANGLE_PI      = 64'd3373259426;
	localparam longint unsigned ANGLE_HALF_PI = 64'd1686629713;
	localparam longint unsigned ANGLE_TWO_PI  = 64'd6746518852;

	// ------------------------------------------------------------------------
	// Expected-sample store plus the tone predictor that fills it.
	// ------------------------------------------------------------------------
	class tone_scoreboard;
		out_word_t                expected_samples [$];
		logic [PHASE_BITS-1:0]    phase_step [NOTE_COUNT];
		logic signed [15:0]       sine_table [SINE_TABLE_DEPTH];
		logic [NOTE_LEN_BITS-1:0] note_len;
		logic [FADE_LEN_BITS-1:0] fade_span;
		logic [PEAK_BITS-1:0]     peak;
		logic [TONE_POS_BITS-1:0] position;
		logic [PHASE_BITS-1:0]    phase;
		int                       errors;
		int                       checked;
		int                       note_ends;
		int                       rests;

		function new();
			longint unsigned ratio_q24 [12];
			longint unsigned a;
			longint unsigned d;
			longint unsigned q;
			longint unsigned r;
			longint unsigned jj;
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint unsigned div_k;
			longint unsigned v;
			longint          sum;
			int              m;
			logic            neg;
			ratio_q24 = '{64'd16777216, 64'd17774841, 64'd18831788, 64'd19951584,
				64'd21137968, 64'd22394897, 64'd23726565, 64'd25137421,
				64'd26632170, 64'd28215801, 64'd29893600, 64'd31671167};
			// Increment per note: 55/8 * 2^((n+3)/12) scaled to a phase turn,
			// long division one bit at a time, rounded half up.
			d = 64'd48000 << 27;
			for (int n = 0; n < NOTE_COUNT; n++) begin
				m = n + 3;
				a = 64'd55 * ratio_q24[m % 12];
				q = a / d;
				r = a % d;
				for (int i = 0; i < m / 12 + PHASE_BITS; i++) begin
					q = q << 1;
					r = r << 1;
					if (r >= d) begin
						r = r - d;
						q = q + 1;
					end
				end
				if ((r << 1) >= d) begin
					q = q + 1;
				end
				phase_step[n] = q[PHASE_BITS-1:0];
			end
			// Sine table: fold into the first quadrant, Taylor series in Q30,
			// round to Q1.15 and saturate the magnitude.
			for (int j = 0; j < SINE_TABLE_DEPTH; j++) begin
				jj  = j;
				x   = (ANGLE_TWO_PI * jj) / SINE_TABLE_DEPTH;
				neg = 1'b0;
				if (x >= ANGLE_PI) begin
					x   = x - ANGLE_PI;
					neg = 1'b1;
				end
				if (x > ANGLE_HALF_PI) begin
					x = ANGLE_PI - x;
				end
				x2   = (x * x) >> 30;
				term = x;
				sum  = 0;
				for (int k = 0; k < 8; k++) begin
					if (k % 2 == 1) begin
						sum = sum - longint'(term);
					end else begin
						sum = sum + longint'(term);
					end
					div_k = (2 * k + 2) * (2 * k + 3);
					term  = ((term * x2) >> 30) / div_k;
				end
				v = (sum < 0) ? 64'd0 : sum;
				v = (v + 64'd16384) >> 15;
				if (v > 64'd32767) begin
					v = 64'd32767;
				end
				sine_table[j] = neg ? -16'(v) : 16'(v);
			end
			note_len  = NOTE_LENGTH_RESET;
			fade_span = FADE_LENGTH_RESET;
			peak      = PEAK_RESET;
			position  = '0;
			phase     = '0;
		endfunction

		function void write_register(logic [CFG_IDX_BITS-1:0] idx,
				logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				CFG_NOTE_LENGTH:    note_len  = value[NOTE_LEN_BITS-1:0];
				CFG_FADE_LENGTH:    fade_span = value[FADE_LEN_BITS-1:0];
				CFG_PEAK_AMPLITUDE: peak      = value[PEAK_BITS-1:0];
				default: ;
			endcase
		endfunction

		// Note one accepted tick and queue the sample it must produce.
		function void note_tick(in_word_t word);
			longint unsigned    magnitude;
			longint unsigned    remaining;
			longint unsigned    numer;
			longint unsigned    denom;
			longint unsigned    pos_next;
			longint             level;
			logic signed [15:0] wave;
			out_word_t          sample_word;
			level = 0;
			if (!word.is_rest) begin
				wave      = sine_table[phase[PHASE_BITS-1 -: SINE_ADDR_BITS]];
				magnitude = (wave < 0) ? -longint'(wave) : longint'(wave);
				// A length cut below the position counts as one sample left.
				remaining = (note_len > position) ? note_len - position : 1;
				if (fade_span != 0 && remaining <= fade_span) begin
					numer = peak * remaining * magnitude;
					denom = fade_span;
					denom = denom << 15;
				end else begin
					numer = peak * magnitude;
					denom = 64'd1 << 15;
				end
				level = numer / denom;
				if (wave < 0) begin
					level = -level;
				end
				phase = phase + phase_step[word.note_number];
			end else begin
				rests++;
			end
			pos_next = position;
			pos_next = pos_next + 1;
			sample_word.end_of_note = (pos_next >= note_len);
			if (sample_word.end_of_note) begin
				position = '0;
				phase    = '0;
				note_ends++;
			end else begin
				position = pos_next[TONE_POS_BITS-1:0];
			end
			sample_word.sample = level[15:0];
			expected_samples.push_back(sample_word);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40) begin
				$display("%0t ns: mismatch: %s", $time, msg);
			end else if (errors == 41) begin
				$display("further mismatches are counted, not printed");
			end
		endtask

		task check_sample(out_word_t got);
			out_word_t want;
			checked++;
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("output word %0d arrived with none expected",
					checked));
			end else begin
				want = expected_samples.pop_front();
				if (got.sample !== want.sample) begin
					report_mismatch($sformatf("word %0d: sample %0d, expected %0d",
						checked, got.sample, want.sample));
				end
				if (got.end_of_note !== want.end_of_note) begin
					report_mismatch($sformatf("word %0d: end_of_note %0b, expected %0b",
						checked, got.end_of_note, want.end_of_note));
				end
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	in_word_t                 in_data;
	logic                     out_valid;
	logic                     out_ready;
	out_word_t                out_data;

	tone_scoreboard sb;
	logic           running       = 1'b0;
	logic           idling_on     = 1'b0;
	logic           long_hold_req = 1'b0;
	int             quiet_cycles  = 0;
	int             settings_used = 0;
	int             long_holds    = 0;

	midi_note_tone_synth_with_fade #(
		.POSITION_BITS(TONE_POS_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Driver tasks
	// ------------------------------------------------------------------------

	// Write one register. Bits above the register width carry junk, which
	// the block must drop. Only called while nothing is in flight.
	task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		logic [CFG_DATA_BITS-1:0] word;
		word = value;
		if (idx == CFG_FADE_LENGTH) begin
			word[CFG_DATA_BITS-1:FADE_LEN_BITS] =
				(CFG_DATA_BITS-FADE_LEN_BITS)'($urandom);
		end else if (idx == CFG_PEAK_AMPLITUDE) begin
			word[CFG_DATA_BITS-1:PEAK_BITS] = (CFG_DATA_BITS-PEAK_BITS)'($urandom);
		end
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_register(idx, word);
	endtask

	// Offer one sample tick, maybe after a short idle burst; hold valid and
	// the word until the block takes it. Valid stays high into the next
	// call when no gap follows.
	task automatic send_tick(input logic [6:0] tone, input logic silent);
		in_word_t word;
		int       gap;
		word.note_number = tone;
		word.is_rest     = silent;
		gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= word;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(word);
	endtask

	// Drop valid and wait until every queued sample has come back, plus a
	// margin so the block is idle for register writes.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (sb.expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Output side: take words, check them, and stall at random. A long hold
	// requested by the stimulus lets the block fill and stop taking input.
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		wait (running);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_sample(out_data);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
				long_holds++;
			end else begin
				if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 10);
				end
				if (stall_left > 0) begin
					out_ready <= 1'b0;
					stall_left--;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (running) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("no word moved for %0d cycles, %0d samples outstanding",
						quiet_cycles, sb.expected_samples.size());
					$display("midi_note_tone_synth_with_fade test failed");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [6:0]               tone;
		logic                     silent;
		logic [NOTE_LEN_BITS-1:0] nl;
		logic [FADE_LEN_BITS-1:0] fl;
		logic [PEAK_BITS-1:0]     pk;
		int                       items;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_NOTE_LENGTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		tone      = 7'd69;
		silent    = 1'b0;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		// Directed: short note with fade, full peak, lowest and highest notes,
		// a rest and a note change inside the note.
		write_cfg(CFG_NOTE_LENGTH, 20'd6);
		write_cfg(CFG_FADE_LENGTH, 20'd3);
		write_cfg(CFG_PEAK_AMPLITUDE, 20'h07FFF);
		settings_used++;
		send_tick(7'd0, 1'b0);
		send_tick(7'd127, 1'b0);
		send_tick(7'd69, 1'b0);
		send_tick(7'd69, 1'b1);
		send_tick(7'd127, 1'b0);
		send_tick(7'd0, 1'b0);
		pause_until_drained();

		// Zero note length: every sample ends the note. Zero fade: no fade.
		write_cfg(CFG_NOTE_LENGTH, 20'd0);
		write_cfg(CFG_FADE_LENGTH, 20'd0);
		settings_used++;
		send_tick(7'd127, 1'b0);
		send_tick(7'd127, 1'b1);
		send_tick(7'd64, 1'b0);
		pause_until_drained();

		// Fade longer than the note: fading from the first sample.
		write_cfg(CFG_NOTE_LENGTH, 20'd4);
		write_cfg(CFG_FADE_LENGTH, 20'h0FFFF);
		write_cfg(CFG_PEAK_AMPLITUDE, 20'd12345);
		settings_used++;
		repeat (4) send_tick(7'($urandom_range(0, 127)), 1'b0);
		pause_until_drained();

		// Cut the length below the current position mid-note: the next sample
		// must end the note with one sample counted as remaining.
		write_cfg(CFG_NOTE_LENGTH, 20'd20);
		write_cfg(CFG_FADE_LENGTH, 20'd5);
		settings_used++;
		repeat (8) send_tick(7'd81, 1'b0);
		pause_until_drained();
		write_cfg(CFG_NOTE_LENGTH, 20'd3);
		settings_used++;
		send_tick(7'd81, 1'b0);
		send_tick(7'd81, 1'b0);
		pause_until_drained();

		// Zero peak, and a write to the unused index that must change nothing.
		write_cfg(CFG_PEAK_AMPLITUDE, 20'd0);
		write_cfg(CFG_UNUSED, 20'hFFFFF);
		settings_used++;
		send_tick(7'd127, 1'b0);
		send_tick(7'd0, 1'b1);
		pause_until_drained();

		// Random phases: melodies that mostly hold a note for its length and
		// change at note starts, with mid-note changes and stray ticks mixed
		// in. Each phase runs under a new register setting, some extreme.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idling_on = (p < RANDOM_PHASES - 2) && (p != 3);
			nl = (p == 1) ? 20'd1 : (p == 5) ? 20'hFFFFF :
				20'($urandom_range(2, (p < 4) ? 40 : 300));
			fl = (p == 0) ? 16'd0 : (p == 3) ? 16'hFFFF : 16'($urandom_range(1, 120));
			pk = (p == 2) ? 15'd0 : (p == 6) ? 15'h7FFF : 15'($urandom_range(1, 32767));
			write_cfg(CFG_NOTE_LENGTH, nl);
			write_cfg(CFG_FADE_LENGTH, CFG_DATA_BITS'(fl));
			write_cfg(CFG_PEAK_AMPLITUDE, CFG_DATA_BITS'(pk));
			settings_used++;
			items = $urandom_range(80, 95);
			for (int i = 0; i < items; i++) begin
				if (sb.position == 0 && $urandom_range(0, 3) != 0) begin
					tone   = 7'($urandom_range(0, 127));
					silent = ($urandom_range(0, 7) == 0);
				end else if ($urandom_range(0, 15) == 0) begin
					tone   = 7'($urandom_range(0, 127));
					silent = ($urandom_range(0, 7) == 0);
				end
				if ($urandom_range(0, 19) == 0) begin
					send_tick(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
				end else begin
					send_tick(tone, silent);
				end
				// Hold the output side off for a long stretch while ticks keep
				// coming, so the block backs up and stalls its input.
				if (p == 2 && i == 20) begin
					long_hold_req = 1'b1;
				end
				// Stop offering until every queued sample is back.
				if (p == 4 && i == 40) begin
					pause_until_drained();
				end
			end
			pause_until_drained();
		end

		$display("Run covered %0d samples (%0d note ends, %0d rests) under %0d settings,",
			sb.checked, sb.note_ends, sb.rests, settings_used);
		$display("with random stalls on both sides, %0d long output hold(s) and drains.",
			long_holds);
		if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
			$display("midi_note_tone_synth_with_fade test passed");
		end else begin
			$display("midi_note_tone_synth_with_fade test failed");
		end
		$finish;
	end

endmodule
